@@ hdl/iqd_pkg.sv @@
// ----------------------------------------------------------------------------
// iqd_pkg: shared types for the block-quantized int8 x uint4 dot product
// Holds the channel payload types, the front-to-back job type and the
// nibble constants.
// ----------------------------------------------------------------------------
`default_nettype none

package iqd_pkg;

  localparam logic [7:0] NIB_MASK  = 8'h0f;
  localparam int         NIB_SHIFT = 4;

  // Widest block sums, reached at the largest block size of 256.
  localparam int PS_MAX_W = 20;
  localparam int AS_MAX_W = 17;

  typedef struct packed {
    logic signed [7:0]  act_low;
    logic signed [7:0]  act_high;
    logic        [7:0]  weight_byte;
    logic signed [23:0] scale_a;
    logic signed [23:0] scale_b;
    logic signed [23:0] min_b;
    logic               last_of_dot;
  } in_t;

  typedef struct packed {
    logic signed [63:0] dot_value;
    logic               saturated;
  } out_t;

  typedef struct packed {
    logic signed [PS_MAX_W-1:0] prod_sum;
    logic signed [AS_MAX_W-1:0] act_sum;
    logic signed [23:0]         scale_a;
    logic signed [23:0]         scale_b;
    logic signed [23:0]         min_b;
    logic                       last;
  } job_t;

  typedef struct packed {
    logic push;
  } q_ctl_t;

endpackage

`default_nettype wire

@@ hdl/iqd_fifo.sv @@
// ----------------------------------------------------------------------------
// iqd_fifo: job queue between front and back
// A small register queue of closed blocks waiting to be scaled.
// ----------------------------------------------------------------------------
`default_nettype none

module iqd_fifo #(
  parameter int DEPTH = 4
) (
  input  wire              clk,
  input  wire              rst_n,
  input  iqd_pkg::q_ctl_t  wr_ctl,
  input  iqd_pkg::job_t    wr_job,
  output logic             q_full,
  input  wire              rd_pop,
  output logic             rd_empty,
  output iqd_pkg::job_t    rd_job
);
  import iqd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign q_full   = (count_r == CNT_W'(DEPTH));
  assign rd_empty = (count_r == '0);
  assign rd_job   = mem_r[rd_ptr_r];
  assign do_push  = wr_ctl.push && !q_full;
  assign do_pop   = rd_pop && !rd_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

endmodule

`default_nettype wire

@@ hdl/iqd_front.sv @@
// ----------------------------------------------------------------------------
// iqd_front: per-item multiply-accumulate
// Accepts items, keeps the integer product and activation sums of the open
// block and queues a job when the block closes.
// ----------------------------------------------------------------------------
`default_nettype none

module iqd_front #(
  parameter int BLOCK_SIZE = 32
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_valid,
  output logic             in_stall,
  input  iqd_pkg::in_t     in_data,
  input  wire              q_full,
  output iqd_pkg::q_ctl_t  q_ctl,
  output iqd_pkg::job_t    q_job
);
  import iqd_pkg::*;

  localparam int HALF  = BLOCK_SIZE / 2;
  localparam int PS_W  = $clog2(HALF * 3840 + 1) + 1;
  localparam int AS_W  = $clog2(HALF * 256 + 1) + 1;
  localparam int CNT_W = (HALF > 1) ? $clog2(HALF) : 1;

  logic signed [PS_W-1:0]  ps_r, ps_nxt, ps_sum;
  logic signed [AS_W-1:0]  as_r, as_nxt, as_sum;
  logic        [CNT_W-1:0] cnt_r, cnt_nxt;
  logic signed [12:0]      prod_lo, prod_hi;
  logic signed [13:0]      prod_item;
  logic signed [8:0]       act_item;
  logic        [3:0]       nib_lo, nib_hi;
  logic                    accept, close;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    nib_lo    = 4'(in_data.weight_byte & NIB_MASK);
    nib_hi    = 4'((in_data.weight_byte >> NIB_SHIFT) & NIB_MASK);
    prod_lo   = in_data.act_low * $signed({1'b0, nib_lo});
    prod_hi   = in_data.act_high * $signed({1'b0, nib_hi});
    prod_item = 14'(prod_lo) + 14'(prod_hi);
    act_item  = 9'(in_data.act_low) + 9'(in_data.act_high);
    ps_sum    = ps_r + PS_W'(prod_item);
    as_sum    = as_r + AS_W'(act_item);
    close     = (cnt_r == CNT_W'(HALF - 1)) || in_data.last_of_dot;

    ps_nxt  = ps_r;
    as_nxt  = as_r;
    cnt_nxt = cnt_r;
    if (accept) begin
      if (close) begin
        ps_nxt  = '0;
        as_nxt  = '0;
        cnt_nxt = '0;
      end else begin
        ps_nxt  = ps_sum;
        as_nxt  = as_sum;
        cnt_nxt = cnt_r + 1'b1;
      end
    end

    q_ctl.push     = accept && close;
    q_job.prod_sum = PS_MAX_W'(ps_sum);
    q_job.act_sum  = AS_MAX_W'(as_sum);
    q_job.scale_a  = in_data.scale_a;
    q_job.scale_b  = in_data.scale_b;
    q_job.min_b    = in_data.min_b;
    q_job.last     = in_data.last_of_dot;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ps_r  <= '0;
      as_r  <= '0;
      cnt_r <= '0;
    end else begin
      ps_r  <= ps_nxt;
      as_r  <= as_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hdl/iqd_back.sv @@
// ----------------------------------------------------------------------------
// iqd_back: block scaling and accumulation
// Takes one job at a time, scales the block sums in fixed point, adds the
// term to the saturating accumulator and registers the result.
// ----------------------------------------------------------------------------
`default_nettype none

module iqd_back (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            q_empty,
  input  iqd_pkg::job_t  q_job,
  output logic           q_pop,
  output logic           out_valid,
  input  wire            out_stall,
  output iqd_pkg::out_t  out_data
);
  import iqd_pkg::*;

  localparam int P_W  = 48;
  localparam int T1_W = P_W + PS_MAX_W;
  localparam int T2_W = P_W + AS_MAX_W;
  localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_SUM,
    ST_ACC
  } state_t;

  state_t              state_r;
  job_t                job_r;
  logic signed [P_W-1:0]  ab_r, am_r;
  logic signed [T1_W-1:0] t1_r;
  logic signed [T2_W-1:0] t2_r;
  logic signed [63:0]  t_r, acc_r;
  logic                ts_r, flag_r;
  logic                out_valid_r;
  out_t                out_r;

  logic signed [63:0]  t1_c, t2_c, t_nxt, acc_nxt;
  logic                t1_s, t2_s, t_s, acc_s;
  logic signed [64:0]  sum_t, sum_acc;
  logic                out_free, emit;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign q_pop     = (state_r == ST_IDLE) && !q_empty;
  assign out_free  = !out_valid_r || !out_stall;
  assign emit      = (state_r == ST_ACC) && job_r.last && out_free;

  always_comb begin
    t1_s = !((&t1_r[T1_W-1:63]) || !(|t1_r[T1_W-1:63]));
    t1_c = t1_s ? (t1_r[T1_W-1] ? S64_MIN : S64_MAX) : t1_r[63:0];
    t2_s = !((&t2_r[T2_W-1:63]) || !(|t2_r[T2_W-1:63]));
    t2_c = t2_s ? (t2_r[T2_W-1] ? S64_MIN : S64_MAX) : t2_r[63:0];

    sum_t = 65'(t1_c) + 65'(t2_c);
    t_s   = sum_t[64] != sum_t[63];
    t_nxt = t_s ? (sum_t[64] ? S64_MIN : S64_MAX) : sum_t[63:0];

    sum_acc = 65'(acc_r) + 65'(t_r);
    acc_s   = sum_acc[64] != sum_acc[63];
    acc_nxt = acc_s ? (sum_acc[64] ? S64_MIN : S64_MAX) : sum_acc[63:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      acc_r       <= '0;
      flag_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (!q_empty) begin
            job_r   <= q_job;
            state_r <= ST_MUL1;
          end
        end
        ST_MUL1: begin
          ab_r    <= job_r.scale_a * job_r.scale_b;
          am_r    <= job_r.scale_a * job_r.min_b;
          state_r <= ST_MUL2;
        end
        ST_MUL2: begin
          t1_r    <= ab_r * job_r.prod_sum;
          t2_r    <= am_r * job_r.act_sum;
          state_r <= ST_SUM;
        end
        ST_SUM: begin
          t_r     <= t_nxt;
          ts_r    <= t1_s || t2_s || t_s;
          state_r <= ST_ACC;
        end
        ST_ACC: begin
          if (!job_r.last) begin
            acc_r   <= acc_nxt;
            flag_r  <= flag_r || ts_r || acc_s;
            state_r <= ST_IDLE;
          end else if (out_free) begin
            out_r.dot_value <= acc_nxt;
            out_r.saturated <= flag_r || ts_r || acc_s;
            acc_r           <= '0;
            flag_r          <= 1'b0;
            state_r         <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hdl/int8_int4_block_quant_dot.sv @@
// ----------------------------------------------------------------------------
// int8_int4_block_quant_dot: block-quantized int8 x uint4 dot product
// out_valid rises once the last block of a dot has left the job queue and
// been scaled. Throughput: one item per cycle while the job queue is not full;
// each block that closes holds the scaling unit for a whole job, and a
// 4-entry job queue absorbs bursts of short blocks before the input stalls.
// Reset (synchronous, active low) clears the block sums, the accumulator, the
// saturation flag, the job queue and the output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module int8_int4_block_quant_dot #(
  parameter int BLOCK_SIZE  = 32,
  parameter int QUEUE_DEPTH = 4
) (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            in_valid,
  output logic           in_stall,
  input  iqd_pkg::in_t   in_data,
  output logic           out_valid,
  input  wire            out_stall,
  output iqd_pkg::out_t  out_data
);
  import iqd_pkg::*;

  q_ctl_t q_ctl;
  job_t   wr_job, rd_job;
  logic   q_full, q_empty, q_pop;

  iqd_front #(
    .BLOCK_SIZE(BLOCK_SIZE)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_ctl    (q_ctl),
    .q_job    (wr_job)
  );

  iqd_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_ctl   (q_ctl),
    .wr_job   (wr_job),
    .q_full   (q_full),
    .rd_pop   (q_pop),
    .rd_empty (q_empty),
    .rd_job   (rd_job)
  );

  iqd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_job     (rd_job),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

@@ hdl/iqd_checker.sv @@
// ----------------------------------------------------------------------------
// iqd_checker: port-level checks for the dot product block
// Tracks finished dot products against results and checks reset and output
// hold behavior.
// ----------------------------------------------------------------------------
`default_nettype none

module iqd_checker (
  input wire           clk,
  input wire           rst_n,
  input wire           in_valid,
  input wire           in_stall,
  input iqd_pkg::in_t  in_data,
  input wire           out_valid,
  input wire           out_stall,
  input iqd_pkg::out_t out_data
);
  import iqd_pkg::*;

  logic [7:0] pending_r;
  logic       in_last_acc, out_acc;

  assign in_last_acc = in_valid && !in_stall && in_data.last_of_dot;
  assign out_acc     = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_r + 8'(in_last_acc) - 8'(out_acc);
    end
  end

  a_result_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pending_r != '0)
    else $error("Result shown without a finished dot product.");

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Result valid right after reset.");

  a_reset_clears_stall: assert property (@(posedge clk)
    !rst_n |=> !in_stall)
    else $error("Input stalled right after reset.");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("Stalled result changed.");

endmodule

bind int8_int4_block_quant_dot iqd_checker u_iqd_checker (.*);

`default_nettype wire

@@ tb/sv/tb_int8_int4_block_quant_dot.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_int8_int4_block_quant_dot: self-checking bench for the block dot product
// Streams directed and random dot products through the block and predicts
// every result in fixed point, then compares each output transaction field by
// field. Both sides idle at random, and some dots are built to saturate.
// ----------------------------------------------------------------------------
module tb_int8_int4_block_quant_dot;
  import iqd_pkg::*;

  localparam int BLOCK_SIZE = 32;
  localparam int HALF_BLOCK = BLOCK_SIZE / 2;
  localparam int ITEM_TARGET = 1900;
  localparam longint Q_MAX = 64'sh7fff_ffff_ffff_ffff;
  localparam longint Q_MIN = 64'sh8000_0000_0000_0000;
  localparam logic signed [23:0] SCALE_MAX = 24'sh7fffff;
  localparam logic signed [23:0] SCALE_MIN = 24'sh800000;

  typedef enum int {DOT_PLAIN, DOT_SAT_UP, DOT_SAT_DOWN} dot_kind_t;

  class dot_product_tracker;
    longint prod_sum;
    longint act_sum;
    longint accum;
    int     pairs;
    bit     sat_seen;
    out_t   pending_dots[$];
    int     mismatch_count;

    function new();
      clear_dot();
      mismatch_count = 0;
    endfunction

    function void clear_dot();
      prod_sum = 0;
      act_sum  = 0;
      accum    = 0;
      pairs    = 0;
      sat_seen = 1'b0;
    endfunction

    function int pending();
      return pending_dots.size();
    endfunction

    function longint clip_mul(longint a, longint b, inout bit s);
      logic signed [127:0] wa, wb, p;
      wa = a;
      wb = b;
      p  = wa * wb;
      if (p > Q_MAX) begin
        s = 1'b1;
        return Q_MAX;
      end
      if (p < Q_MIN) begin
        s = 1'b1;
        return Q_MIN;
      end
      return longint'(p);
    endfunction

    function longint clip_add(longint a, longint b, inout bit s);
      logic signed [64:0] wa, wb, sum;
      wa  = a;
      wb  = b;
      sum = wa + wb;
      if (sum > Q_MAX) begin
        s = 1'b1;
        return Q_MAX;
      end
      if (sum < Q_MIN) begin
        s = 1'b1;
        return Q_MIN;
      end
      return longint'(sum);
    endfunction

    function void note_transaction(in_t item);
      longint al, ah, wl, wh, sa, sb, mb, t1, t2, term;
      bit     s;
      out_t   res;
      al = item.act_low;
      ah = item.act_high;
      wl = longint'(item.weight_byte & NIB_MASK);
      wh = longint'((item.weight_byte >> NIB_SHIFT) & NIB_MASK);
      sa = item.scale_a;
      sb = item.scale_b;
      mb = item.min_b;
      prod_sum += al * wl + ah * wh;
      act_sum  += al + ah;
      pairs++;
      if (pairs >= HALF_BLOCK || item.last_of_dot) begin
        s     = 1'b0;
        t1    = clip_mul(sa * sb, prod_sum, s);
        t2    = clip_mul(sa * mb, act_sum, s);
        term  = clip_add(t1, t2, s);
        accum = clip_add(accum, term, s);
        if (s) begin
          sat_seen = 1'b1;
        end
        prod_sum = 0;
        act_sum  = 0;
        pairs    = 0;
      end
      if (item.last_of_dot) begin
        res.dot_value = accum;
        res.saturated = sat_seen;
        pending_dots.push_back(res);
        clear_dot();
      end
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatch_count++;
    endtask

    task check_transaction(out_t got);
      out_t want;
      if (pending_dots.size() == 0) begin
        report_mismatch($sformatf("unexpected result dot_value=%h saturated=%b",
                                  got.dot_value, got.saturated));
        return;
      end
      want = pending_dots.pop_front();
      if (got.dot_value !== want.dot_value) begin
        report_mismatch($sformatf("dot_value got %h want %h",
                                  got.dot_value, want.dot_value));
      end
      if (got.saturated !== want.saturated) begin
        report_mismatch($sformatf("saturated got %b want %b",
                                  got.saturated, want.saturated));
      end
    endtask

    task finish_check();
      if (pending_dots.size() != 0) begin
        report_mismatch($sformatf("%0d results never arrived", pending_dots.size()));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  bit calm = 1'b0;
  int items_sent = 0;
  dot_product_tracker tracker;

  int8_int4_block_quant_dot #(
    .BLOCK_SIZE(BLOCK_SIZE)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 33);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      tracker.check_transaction(out_data);
    end
  end

  function automatic in_t make_item(logic signed [7:0] al, logic signed [7:0] ah,
                                    logic [7:0] wb, logic signed [23:0] sa,
                                    logic signed [23:0] sb, logic signed [23:0] mb,
                                    logic last);
    in_t it;
    it.act_low     = al;
    it.act_high    = ah;
    it.weight_byte = wb;
    it.scale_a     = sa;
    it.scale_b     = sb;
    it.min_b       = mb;
    it.last_of_dot = last;
    return it;
  endfunction

  function automatic in_t random_item(dot_kind_t kind, logic last);
    in_t it;
    it.act_low     = 8'($urandom);
    it.act_high    = 8'($urandom);
    it.weight_byte = 8'($urandom);
    it.scale_a     = 24'($urandom);
    it.scale_b     = 24'($urandom);
    it.min_b       = 24'($urandom);
    it.last_of_dot = last;
    if (kind != DOT_PLAIN) begin
      it.act_low     = (kind == DOT_SAT_UP) ? 8'sd127 : -8'sd128;
      it.act_high    = it.act_low;
      it.weight_byte = 8'hff;
      it.scale_a     = SCALE_MIN + 24'($urandom_range(63));
      it.scale_b     = SCALE_MIN + 24'($urandom_range(63));
      it.min_b       = SCALE_MIN + 24'($urandom_range(63));
    end
    return it;
  endfunction

  task automatic drive_item(input in_t item);
    while (!calm && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    tracker.note_transaction(item);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic drive_random_dot();
    dot_kind_t kind;
    int        len;
    int        pick;
    pick = $urandom_range(99);
    kind = DOT_PLAIN;
    if (pick < 6) begin
      kind = DOT_SAT_UP;
    end else if (pick < 12) begin
      kind = DOT_SAT_DOWN;
    end
    if (kind != DOT_PLAIN) begin
      len = $urandom_range(80, 40);
    end else if (pick < 35) begin
      len = $urandom_range(3, 1);
    end else if (pick < 85) begin
      len = $urandom_range(40, 4);
    end else begin
      len = $urandom_range(80, 41);
    end
    for (int i = 0; i < len; i++) begin
      calm = (items_sent >= 500 && items_sent < 800);
      drive_item(random_item(kind, i == len - 1));
    end
  endtask

  initial begin
    bit drained_once;
    drained_once = 1'b0;
    tracker = new();
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    drive_item(make_item(-8'sd128, 8'sd127, 8'hff, SCALE_MIN, SCALE_MAX, SCALE_MIN, 1'b1));
    drive_item(make_item(8'sd127, -8'sd128, 8'h0f, SCALE_MAX, SCALE_MAX, SCALE_MAX, 1'b1));
    drive_item(make_item(8'sd0, 8'sd0, 8'h00, 24'sd0, 24'sd0, 24'sd0, 1'b1));
    drive_item(make_item(-8'sd1, 8'sd1, 8'hf0, SCALE_MIN, SCALE_MIN, SCALE_MAX, 1'b1));
    for (int i = 0; i < HALF_BLOCK; i++) begin
      drive_item(random_item(DOT_PLAIN, i == HALF_BLOCK - 1));
    end
    drive_item(make_item(8'sd127, 8'sd127, 8'hff, SCALE_MAX, SCALE_MIN, SCALE_MAX, 1'b0));
    drive_item(make_item(-8'sd128, -8'sd128, 8'hff, SCALE_MIN, SCALE_MAX, SCALE_MIN, 1'b0));
    drive_item(make_item(8'sd127, -8'sd128, 8'h5a, SCALE_MAX, SCALE_MIN, SCALE_MAX, 1'b1));

    while (items_sent < ITEM_TARGET) begin
      if (!drained_once && items_sent >= 1000) begin
        drained_once = 1'b1;
        in_valid <= 1'b0;
        do @(negedge clk); while (tracker.pending() != 0);
      end
      drive_random_dot();
    end
    calm = 1'b0;

    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    tracker.finish_check();
    if (tracker.mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TIMEOUT at %0t", $realtime);
    $display("Test completed with failures");
    $finish;
  end

endmodule

@@ int8_int4_block_quant_dot.f @@
hdl/iqd_pkg.sv
hdl/iqd_fifo.sv
hdl/iqd_front.sv
hdl/iqd_back.sv
hdl/int8_int4_block_quant_dot.sv
hdl/iqd_checker.sv
tb/sv/tb_int8_int4_block_quant_dot.sv
